// ===== hw/rtl/dgc_pkg.sv =====
// Shared types and constants of the decimating RGB to gray converter.
package dgc_pkg;

  // Field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned DimW   = 12;
  localparam int unsigned ScaleW = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOutWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOutHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgScaleX    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgScaleY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGrayMode  = 3'd4;

  // Reset values of the registers
  localparam logic [DimW-1:0]   RstOutWidth  = 12'd640;
  localparam logic [DimW-1:0]   RstOutHeight = 12'd480;
  localparam logic [ScaleW-1:0] RstScale     = 5'd1;

  // Luma: floor(sum / 1000) done as sum * ceil(2^28 / 1000) >> 28, exact for
  // sums up to 255000. The reciprocal is folded into each channel weight.
  localparam int unsigned LumaW     = 37;
  localparam int unsigned LumaShift = 28;
  localparam logic [LumaW-1:0] LumaKRed   = 37'd80262364;   // 299 * 268436
  localparam logic [LumaW-1:0] LumaKGreen = 37'd157571932;  // 587 * 268436
  localparam logic [LumaW-1:0] LumaKBlue  = 37'd30601704;   // 114 * 268436

  // Live configuration seen by the datapath
  typedef struct packed {
    logic [DimW-1:0]   out_width;
    logic [DimW-1:0]   out_height;
    logic [ScaleW-1:0] scale_x;
    logic [ScaleW-1:0] scale_y;
    logic              gray_mode;
    logic              bad;
  } cfg_t;

  // Raster position flags for the current source pixel
  typedef struct packed {
    logic keep;
    logic eol;
    logic eof;
  } raster_t;

  // One kept pixel on its way to the output register
  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic            gray_mode;
    logic            eol;
    logic            eof;
    logic            err;
  } pix_t;

endpackage

// ===== hw/rtl/dgc_cfg.sv =====
// Configuration registers and the source size check.
module dgc_cfg
  import dgc_pkg::*;
#(
  parameter int unsigned MAX_SRC_WIDTH  = 2048,
  parameter int unsigned MAX_SRC_HEIGHT = 2048,
  parameter int unsigned MAX_SCALE      = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o,
  output logic                restart_o
);

  logic [DimW-1:0]   out_width_q, out_height_q;
  logic [ScaleW-1:0] scale_x_q, scale_y_q;
  logic              gray_mode_q;
  logic              hit;
  logic [DimW+ScaleW-1:0] src_w, src_h;

  // Decode the write index
  always_comb begin
    unique case (cfg_index_i) inside
      CfgOutWidth, CfgOutHeight, CfgScaleX, CfgScaleY, CfgGrayMode: hit = 1'b1;
      default: hit = 1'b0;
    endcase
  end

  assign restart_o = cfg_valid_i && hit;

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= RstOutWidth;
      out_height_q <= RstOutHeight;
      scale_x_q    <= RstScale;
      scale_y_q    <= RstScale;
      gray_mode_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOutWidth:  out_width_q  <= cfg_data_i[DimW-1:0];
        CfgOutHeight: out_height_q <= cfg_data_i[DimW-1:0];
        CfgScaleX:    scale_x_q    <= cfg_data_i[ScaleW-1:0];
        CfgScaleY:    scale_y_q    <= cfg_data_i[ScaleW-1:0];
        CfgGrayMode:  gray_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Check the scaled source size against the built bounds
  assign src_w = (DimW+ScaleW)'(out_width_q) * (DimW+ScaleW)'(scale_x_q);
  assign src_h = (DimW+ScaleW)'(out_height_q) * (DimW+ScaleW)'(scale_y_q);

  assign cfg_o.out_width  = out_width_q;
  assign cfg_o.out_height = out_height_q;
  assign cfg_o.scale_x    = scale_x_q;
  assign cfg_o.scale_y    = scale_y_q;
  assign cfg_o.gray_mode  = gray_mode_q;
  assign cfg_o.bad = (out_width_q == '0) || (out_height_q == '0) ||
                     (scale_x_q == '0) || (scale_y_q == '0) ||
                     (32'(scale_x_q) > MAX_SCALE) || (32'(scale_y_q) > MAX_SCALE) ||
                     (32'(src_w) > MAX_SRC_WIDTH) || (32'(src_h) > MAX_SRC_HEIGHT);

endmodule

// ===== hw/rtl/dgc_raster.sv =====
// Raster position counters that pick the top-left pixel of each cell.
module dgc_raster
  import dgc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    restart_i,
  input  logic    advance_i,
  output raster_t pos_o
);

  logic [ScaleW-1:0] col_phase_q, col_phase_d, row_phase_q, row_phase_d;
  logic [DimW-1:0]   out_col_q, out_col_d, out_row_q, out_row_d;
  logic              col_wrap, line_wrap, row_wrap, frame_wrap;

  // Flag the current pixel
  assign pos_o.keep = (col_phase_q == '0) && (row_phase_q == '0);
  assign pos_o.eol  = (out_col_q == cfg_i.out_width - DimW'(1));
  assign pos_o.eof  = pos_o.eol && (out_row_q == cfg_i.out_height - DimW'(1));

  assign col_wrap   = ({1'b0, col_phase_q} + 6'd1) >= {1'b0, cfg_i.scale_x};
  assign line_wrap  = ({1'b0, out_col_q} + 13'd1) >= {1'b0, cfg_i.out_width};
  assign row_wrap   = ({1'b0, row_phase_q} + 6'd1) >= {1'b0, cfg_i.scale_y};
  assign frame_wrap = ({1'b0, out_row_q} + 13'd1) >= {1'b0, cfg_i.out_height};

  // Advance the position by one source pixel
  always_comb begin
    col_phase_d = col_phase_q;
    row_phase_d = row_phase_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    if (restart_i || (advance_i && cfg_i.bad)) begin
      col_phase_d = '0;
      row_phase_d = '0;
      out_col_d   = '0;
      out_row_d   = '0;
    end else if (advance_i) begin
      col_phase_d = col_phase_q + ScaleW'(1);
      if (col_wrap) begin
        col_phase_d = '0;
        out_col_d   = out_col_q + DimW'(1);
        if (line_wrap) begin
          out_col_d   = '0;
          row_phase_d = row_phase_q + ScaleW'(1);
          if (row_wrap) begin
            row_phase_d = '0;
            out_row_d   = out_row_q + DimW'(1);
            if (frame_wrap) out_row_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_phase_q <= '0;
      row_phase_q <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
    end else begin
      col_phase_q <= col_phase_d;
      row_phase_q <= row_phase_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
    end
  end

  // Positions stay inside the configured frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_i.bad |-> (col_phase_q < cfg_i.scale_x) && (row_phase_q < cfg_i.scale_y))
    else $error("cell phase beyond scale");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_i.bad |-> (out_col_q < cfg_i.out_width) && (out_row_q < cfg_i.out_height))
    else $error("output position beyond frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && cfg_i.bad |=> (out_col_q == '0) && (col_phase_q == '0))
    else $error("counters moved under bad configuration");

endmodule

// ===== hw/rtl/dgc_luma_stage.sv =====
// Luma weighting and the output register of the master beat.
module dgc_luma_stage
  import dgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pix_t        in_pix_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_gray
  output logic        m_axis_tlast,   // end_of_line
  output logic [1:0]  m_axis_tuser    // end_of_frame, config_error
);

  logic [LumaW-1:0] luma_sum;
  logic [PixW-1:0]  gray;
  logic [31:0]      tdata_d;
  logic             tlast_d;
  logic [1:0]       tuser_d;
  logic             valid_q;
  logic [31:0]      tdata_q;
  logic             tlast_q;
  logic [1:0]       tuser_q;

  // Weighted sum with the reciprocal of 1000 folded in
  assign luma_sum = LumaW'(in_pix_i.red) * LumaKRed +
                    LumaW'(in_pix_i.green) * LumaKGreen +
                    LumaW'(in_pix_i.blue) * LumaKBlue;
  assign gray = luma_sum[LumaShift +: PixW];

  // Select the beat contents
  always_comb begin
    tdata_d = '0;
    tlast_d = 1'b0;
    tuser_d = 2'b10;
    if (!in_pix_i.err) begin
      tlast_d = in_pix_i.eol;
      tuser_d = {1'b0, in_pix_i.eof};
      if (in_pix_i.gray_mode) tdata_d = {gray, 24'd0};
      else tdata_d = {8'd0, in_pix_i.blue, in_pix_i.green, in_pix_i.red};
    end
  end

  assign in_ready_o = !valid_q || m_axis_tready;

  // Load a new beat when the register is empty or drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tdata_q <= tdata_d;
      tlast_q <= tlast_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;
  assign m_axis_tuser  = tuser_q;

  // Beat contents stay consistent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && tuser_q[1] |-> (tdata_q == '0) && !tlast_q && !tuser_q[0])
    else $error("error beat carries pixel data");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && tuser_q[0] |-> tlast_q)
    else $error("end of frame without end of line");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (tdata_q[31:24] != '0) |-> (tdata_q[23:0] == '0))
    else $error("gray and color fields both set");

endmodule

// ===== hw/rtl/decimating_rgb_gray_converter_core.sv =====
// Top level of the decimating RGB to gray converter.
//
// Source pixels arrive in raster order on the slave stream, one per beat, with
// red, green and blue in tdata. Of each scale_x by scale_y cell only the
// top-left pixel leaves on the master stream, either as RGB or, in gray mode,
// as floor((299R + 587G + 114B) / 1000) in the top byte. tlast marks the end
// of an output line and tuser the end of the frame and a configuration error.
// With an unusable configuration every source pixel yields one error beat.
// Registers are written on the cfg channel, which is always ready; a write to
// a known index restarts the frame. Write only while the block is drained.
//
// Throughput is one pixel per cycle while the master side accepts beats. A kept
// pixel passes the input register, then the luma sum and the output register,
// on its way to the master side. A stalled master fills the two registers, and
// tready on the slave side drops only once both hold a beat. Reset loads the
// register defaults (640 x 480, scale 1, color mode) and empties both stages.
module decimating_rgb_gray_converter_core
  import dgc_pkg::*;
#(
  parameter int unsigned MAX_SRC_WIDTH  = 2048,
  parameter int unsigned MAX_SRC_HEIGHT = 2048,
  parameter int unsigned MAX_SCALE      = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // red, green, blue
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // out_red, out_green, out_blue, out_gray
  output logic                m_axis_tlast,   // end_of_line
  output logic [1:0]          m_axis_tuser,   // end_of_frame, config_error
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  raster_t pos;
  logic    restart;
  logic    in_fire;
  logic    s1_valid_q;
  pix_t    s1_pix_q;
  pix_t    s1_pix_d;
  logic    s2_ready;

  assign cfg_ready_o = 1'b1;

  dgc_cfg #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .MAX_SCALE     (MAX_SCALE)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .restart_o  (restart)
  );

  assign s_axis_tready = !s1_valid_q || s2_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  dgc_raster u_raster (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .restart_i(restart),
    .advance_i(in_fire),
    .pos_o    (pos)
  );

  // Capture the pixel with its position flags
  assign s1_pix_d.red       = s_axis_tdata[7:0];
  assign s1_pix_d.green     = s_axis_tdata[15:8];
  assign s1_pix_d.blue      = s_axis_tdata[23:16];
  assign s1_pix_d.gray_mode = cfg.gray_mode;
  assign s1_pix_d.eol       = pos.eol;
  assign s1_pix_d.eof       = pos.eof;
  assign s1_pix_d.err       = cfg.bad;

  // Input register: load only kept pixels and error beats, drop the rest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= in_fire && (pos.keep || cfg.bad);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= s1_pix_d;
    end
  end

  dgc_luma_stage u_luma (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s1_valid_q),
    .in_ready_o   (s2_ready),
    .in_pix_i     (s1_pix_q),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // A full input register waits while the output stage is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_pix_q))
    else $error("input register lost a beat");
  // Under a bad configuration every accepted pixel enters the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && cfg.bad |=> s1_valid_q && s1_pix_q.err)
    else $error("error beat dropped");
  // End of frame is only flagged on the end of a line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_pix_q.eof && !s1_pix_q.err |-> s1_pix_q.eol)
    else $error("frame end off a line end");

endmodule
